[rtl/core/free_id_stack_allocator_defines.svh]
// assertion macros for the free id stack allocator
// used by rtl/core/free_id_stack_allocator.sv; expects clk and rst_n in scope
`ifndef FREE_ID_STACK_ALLOCATOR_DEFINES_SVH
`define FREE_ID_STACK_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS

`define FIDS_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define FIDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define FIDS_ASSERT(lbl, expr, msg)
`define FIDS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[rtl/core/fids_pkg.sv]
// types, codes and microcode rom for the free id stack allocator
// no dependencies; used by rtl/core/free_id_stack_allocator.sv
package fids_pkg;

  localparam int ID_W   = 16;
  localparam int ACT_W  = 3;
  localparam int STAT_W = 2;
  localparam int STEP_W = 4;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_GET     = 3'd0,
    ACT_RELEASE = 3'd1,
    ACT_BEGIN   = 3'd2,
    ACT_MARK    = 3'd3,
    ACT_FINISH  = 3'd4
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_GRANTED   = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_FULL      = 2'd2,
    ST_DONE      = 2'd3
  } status_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [ID_W-1:0]  id_value;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0]   granted_id;
    logic [STAT_W-1:0] status;
  } out_item_t;

  // datapath operations, one per control word
  typedef enum logic [3:0] {
    OP_NOP      = 4'd0,
    OP_INIT_CLR = 4'd1,
    OP_FETCH    = 4'd2,
    OP_SET_EXH  = 4'd3,
    OP_GROW     = 4'd4,
    OP_FILL     = 4'd5,
    OP_POP      = 4'd6,
    OP_RELEASE  = 4'd7,
    OP_BEGIN    = 4'd8,
    OP_CLR_MARK = 4'd9,
    OP_CLR_HIGH = 4'd10,
    OP_MARK     = 4'd11,
    OP_FIN_INIT = 4'd12,
    OP_FIN_RD   = 4'd13,
    OP_EMIT     = 4'd14
  } op_t;

  // jump conditions
  typedef enum logic [3:0] {
    C_ALWAYS    = 4'd0,
    C_IN_ACC    = 4'd1,
    C_TOP_ZERO  = 4'd2,
    C_SIZE_FULL = 4'd3,
    C_CNT_MORE  = 4'd4,
    C_FILL_MORE = 4'd5,
    C_HIGH_ZERO = 4'd6,
    C_CLR_MORE  = 4'd7,
    C_WALK_MORE = 4'd8,
    C_OUT_BUSY  = 4'd9
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    logic  disp;    // on a taken jump, go to the action's entry step
    step_t jt;      // next step when cond holds
    step_t jf;      // next step otherwise
  } ucw_t;

  localparam step_t S_RST   = 4'd0;
  localparam step_t S_FETCH = 4'd1;
  localparam step_t S_GET   = 4'd2;
  localparam step_t S_GCHK  = 4'd3;
  localparam step_t S_EXH   = 4'd4;
  localparam step_t S_GROW  = 4'd5;
  localparam step_t S_FILL  = 4'd6;
  localparam step_t S_POP   = 4'd7;
  localparam step_t S_REL   = 4'd8;
  localparam step_t S_BEG   = 4'd9;
  localparam step_t S_BCLR  = 4'd10;
  localparam step_t S_BEND  = 4'd11;
  localparam step_t S_MARK  = 4'd12;
  localparam step_t S_FIN   = 4'd13;
  localparam step_t S_FRD   = 4'd14;
  localparam step_t S_EMIT  = 4'd15;

  function automatic ucw_t ucode_rom(input step_t step);
    ucw_t w;
    unique case (step)
      S_RST:   w = '{OP_INIT_CLR, C_CNT_MORE,  1'b0, S_RST,  S_FETCH};
      S_FETCH: w = '{OP_FETCH,    C_IN_ACC,    1'b1, S_FETCH, S_FETCH};
      S_GET:   w = '{OP_NOP,      C_TOP_ZERO,  1'b0, S_GCHK, S_POP};
      S_GCHK:  w = '{OP_NOP,      C_SIZE_FULL, 1'b0, S_EXH,  S_GROW};
      S_EXH:   w = '{OP_SET_EXH,  C_ALWAYS,    1'b0, S_EMIT, S_EMIT};
      S_GROW:  w = '{OP_GROW,     C_ALWAYS,    1'b0, S_FILL, S_FILL};
      S_FILL:  w = '{OP_FILL,     C_FILL_MORE, 1'b0, S_FILL, S_POP};
      S_POP:   w = '{OP_POP,      C_ALWAYS,    1'b0, S_EMIT, S_EMIT};
      S_REL:   w = '{OP_RELEASE,  C_ALWAYS,    1'b0, S_EMIT, S_EMIT};
      S_BEG:   w = '{OP_BEGIN,    C_HIGH_ZERO, 1'b0, S_BEND, S_BCLR};
      S_BCLR:  w = '{OP_CLR_MARK, C_CLR_MORE,  1'b0, S_BCLR, S_BEND};
      S_BEND:  w = '{OP_CLR_HIGH, C_ALWAYS,    1'b0, S_EMIT, S_EMIT};
      S_MARK:  w = '{OP_MARK,     C_ALWAYS,    1'b0, S_EMIT, S_EMIT};
      S_FIN:   w = '{OP_FIN_INIT, C_ALWAYS,    1'b0, S_FRD,  S_FRD};
      S_FRD:   w = '{OP_FIN_RD,   C_WALK_MORE, 1'b0, S_FRD,  S_BEND};
      S_EMIT:  w = '{OP_EMIT,     C_OUT_BUSY,  1'b0, S_EMIT, S_FETCH};
      default: w = '{OP_NOP,      C_ALWAYS,    1'b0, S_FETCH, S_FETCH};
    endcase
    return w;
  endfunction

  // entry step for each action; unknown actions only report done
  function automatic step_t dispatch(input logic [ACT_W-1:0] action);
    step_t s;
    unique case (action)
      ACT_GET:     s = S_GET;
      ACT_RELEASE: s = S_REL;
      ACT_BEGIN:   s = S_BEG;
      ACT_MARK:    s = S_MARK;
      ACT_FINISH:  s = S_FIN;
      default:     s = S_EMIT;
    endcase
    return s;
  endfunction

endpackage

[rtl/core/free_id_stack_allocator.sv]
// Free id stack allocator.
// Input channel (in_valid/in_stall/in_data) takes one command word: get, release,
// restore begin, restore mark and restore finish. The output channel
// (out_valid/out_stall/out_data) returns exactly one word per command: the granted
// id and a status. One command is worked on at a time by a microcoded sequencer;
// in_stall is low only while the sequencer waits in its fetch step.
// From accept to out_valid, a get runs its check, pop and emit steps; release and
// mark run their own step, then emit; an unknown action goes straight to emit. A get
// that finds the stack empty first refills it through the size check, grow and fill
// steps before the pop (size check, then the exhausted step when the ids are
// exhausted). Restore begin clears the marks up to the highest marked id; restore
// finish walks the mark and stack memories over the new active size. The single write
// port of the id stack sets these walks. The fetch step follows the result load.
// After reset the block runs a clearing pass over all ID_CAPACITY entries (used marks
// cleared, initial ids loaded) with in_stall high.
// The result sits in an output register; while out_stall is high the word
// holds, and the next command may still be accepted and worked on up to its
// result, which then waits for the register to free.
// depends on fids_pkg and free_id_stack_allocator_defines.svh
`include "free_id_stack_allocator_defines.svh"

module free_id_stack_allocator #(
  parameter int ID_CAPACITY  = 256,
  parameter int FIRST_ID     = 1,
  parameter int INITIAL_SIZE = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  fids_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output fids_pkg::out_item_t out_data
);

  localparam int CW      = $clog2(ID_CAPACITY + 1);
  localparam int AW      = $clog2(ID_CAPACITY);
  localparam int INIT_SZ = (INITIAL_SIZE < ID_CAPACITY) ? INITIAL_SIZE : ID_CAPACITY;
  localparam logic [16:0] FIRST_W = 17'(FIRST_ID);

  // memories
  logic [fids_pkg::ID_W-1:0] stack_mem [ID_CAPACITY];
  logic                      mark_mem  [ID_CAPACITY];

  // sequencer and datapath registers
  fids_pkg::step_t     step_r, step_nxt;
  logic [CW-1:0]       top_r, top_nxt;
  logic [CW-1:0]       size_r, size_nxt;
  logic [CW-1:0]       high_r, high_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                pv_r, pv_nxt;
  logic [AW-1:0]       pidx_r, pidx_nxt;
  logic [fids_pkg::ID_W-1:0] id_r, id_nxt;
  fids_pkg::status_t   res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  fids_pkg::out_item_t out_data_r, out_data_nxt;
  logic [fids_pkg::ID_W-1:0] stack_rd_r;
  logic                mark_rd_r;

  // memory port controls
  logic                      stk_we, stk_re;
  logic [AW-1:0]             stk_wa, stk_ra;
  logic [fids_pkg::ID_W-1:0] stk_wd;
  logic                      mk_we, mk_re, mk_wd;
  logic [AW-1:0]             mk_wa, mk_ra;

  fids_pkg::ucw_t ucw;
  logic           in_acc;
  logic           out_busy;
  logic           cond_hit;
  logic [CW:0]    dbl_sz;
  logic [CW-1:0]  grow_sz;
  logic [CW-1:0]  cnt_dec;
  logic [CW-1:0]  top_dec;
  logic [16:0]    mark_idx;
  logic           mark_ok;
  logic           mark_in_range;
  logic [CW-1:0]  mark_need;

  assign ucw      = fids_pkg::ucode_rom(step_r);
  assign in_stall = (step_r != fids_pkg::S_FETCH);
  assign in_acc   = in_valid && !in_stall;
  assign out_busy = out_valid_r && out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign dbl_sz  = {size_r, 1'b0};
  assign grow_sz = (dbl_sz > (CW+1)'(ID_CAPACITY)) ? CW'(ID_CAPACITY) : dbl_sz[CW-1:0];
  assign cnt_dec = cnt_r - CW'(1);
  assign top_dec = top_r - CW'(1);

  assign mark_idx      = 17'(id_r) - FIRST_W;
  assign mark_ok       = (17'(id_r) >= FIRST_W);
  assign mark_in_range = (mark_idx < 17'(ID_CAPACITY));
  assign mark_need     = mark_in_range ? CW'(mark_idx + 17'd1) : CW'(ID_CAPACITY);

  always_comb begin
    unique case (ucw.cond)
      fids_pkg::C_ALWAYS:    cond_hit = 1'b1;
      fids_pkg::C_IN_ACC:    cond_hit = in_acc;
      fids_pkg::C_TOP_ZERO:  cond_hit = (top_r == '0);
      fids_pkg::C_SIZE_FULL: cond_hit = (size_r >= CW'(ID_CAPACITY));
      fids_pkg::C_CNT_MORE:  cond_hit = (cnt_r != CW'(ID_CAPACITY - 1));
      fids_pkg::C_FILL_MORE: cond_hit = (cnt_r != top_dec);
      fids_pkg::C_HIGH_ZERO: cond_hit = (high_r == '0);
      fids_pkg::C_CLR_MORE:  cond_hit = (cnt_r != high_r - CW'(1));
      fids_pkg::C_WALK_MORE: cond_hit = (cnt_r != CW'(1));
      fids_pkg::C_OUT_BUSY:  cond_hit = out_busy;
      default:               cond_hit = 1'b0;
    endcase
    if (cond_hit) begin
      step_nxt = ucw.disp ? fids_pkg::dispatch(in_data.action) : ucw.jt;
    end else begin
      step_nxt = ucw.jf;
    end
  end

  always_comb begin
    top_nxt       = top_r;
    size_nxt      = size_r;
    high_nxt      = high_r;
    cnt_nxt       = cnt_r;
    pv_nxt        = 1'b0;
    pidx_nxt      = pidx_r;
    id_nxt        = id_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    stk_we = 1'b0;
    stk_wa = top_r[AW-1:0];
    stk_wd = id_r;
    stk_re = 1'b0;
    stk_ra = top_dec[AW-1:0];
    mk_we  = 1'b0;
    mk_wa  = cnt_r[AW-1:0];
    mk_wd  = 1'b0;
    mk_re  = 1'b0;
    mk_ra  = cnt_dec[AW-1:0];

    // restore walk: push the id whose mark was read in the cycle before if it was not marked
    if (pv_r && !mark_rd_r) begin
      stk_we  = 1'b1;
      stk_wa  = top_r[AW-1:0];
      stk_wd  = 16'(FIRST_W + 17'(pidx_r));
      top_nxt = top_r + CW'(1);
    end

    unique case (ucw.op)
      fids_pkg::OP_INIT_CLR: begin
        mk_we   = 1'b1;
        mk_wa   = cnt_r[AW-1:0];
        if (cnt_r < CW'(INIT_SZ)) begin
          stk_we = 1'b1;
          stk_wa = cnt_r[AW-1:0];
          stk_wd = 16'(FIRST_W + 17'(INIT_SZ - 1) - 17'(cnt_r));
        end
        cnt_nxt = cnt_r + CW'(1);
      end
      fids_pkg::OP_FETCH: begin
        if (in_acc) begin
          id_nxt  = in_data.id_value;
          res_nxt = fids_pkg::ST_DONE;
        end
      end
      fids_pkg::OP_SET_EXH: begin
        res_nxt = fids_pkg::ST_EXHAUSTED;
      end
      fids_pkg::OP_GROW: begin
        size_nxt = grow_sz;
        top_nxt  = grow_sz - size_r;
        cnt_nxt  = '0;
      end
      fids_pkg::OP_FILL: begin
        // new ids go in highest first so they pop ascending
        stk_we  = 1'b1;
        stk_wa  = cnt_r[AW-1:0];
        stk_wd  = 16'(FIRST_W + 17'(size_r) - 17'(cnt_r) - 17'd1);
        cnt_nxt = cnt_r + CW'(1);
      end
      fids_pkg::OP_POP: begin
        stk_re  = 1'b1;
        stk_ra  = top_dec[AW-1:0];
        top_nxt = top_dec;
        res_nxt = fids_pkg::ST_GRANTED;
      end
      fids_pkg::OP_RELEASE: begin
        if (top_r >= size_r) begin
          res_nxt = fids_pkg::ST_FULL;
        end else begin
          stk_we  = 1'b1;
          stk_wa  = top_r[AW-1:0];
          stk_wd  = id_r;
          top_nxt = top_r + CW'(1);
        end
      end
      fids_pkg::OP_BEGIN: begin
        cnt_nxt = '0;
      end
      fids_pkg::OP_CLR_MARK: begin
        mk_we   = 1'b1;
        mk_wa   = cnt_r[AW-1:0];
        cnt_nxt = cnt_r + CW'(1);
      end
      fids_pkg::OP_CLR_HIGH: begin
        high_nxt = '0;
      end
      fids_pkg::OP_MARK: begin
        if (mark_ok) begin
          if (mark_need > high_r) begin
            high_nxt = mark_need;
          end
          if (mark_in_range) begin
            mk_we = 1'b1;
            mk_wa = mark_idx[AW-1:0];
            mk_wd = 1'b1;
          end
        end
      end
      fids_pkg::OP_FIN_INIT: begin
        // size only grows; every mark lies below the new size
        size_nxt = (high_r > size_r) ? high_r : size_r;
        cnt_nxt  = (high_r > size_r) ? high_r : size_r;
        top_nxt  = '0;
      end
      fids_pkg::OP_FIN_RD: begin
        mk_re    = 1'b1;
        mk_ra    = cnt_dec[AW-1:0];
        mk_we    = 1'b1;
        mk_wa    = cnt_dec[AW-1:0];
        pv_nxt   = 1'b1;
        pidx_nxt = cnt_dec[AW-1:0];
        cnt_nxt  = cnt_dec;
      end
      fids_pkg::OP_EMIT: begin
        if (!out_busy) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.status     = res_r;
          out_data_nxt.granted_id = (res_r == fids_pkg::ST_GRANTED) ? stack_rd_r : '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= fids_pkg::S_RST;
      top_r       <= CW'(INIT_SZ);
      size_r      <= CW'(INIT_SZ);
      high_r      <= '0;
      cnt_r       <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      top_r       <= top_nxt;
      size_r      <= size_nxt;
      high_r      <= high_nxt;
      cnt_r       <= cnt_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pidx_r     <= pidx_nxt;
    id_r       <= id_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[stk_wa] <= stk_wd;
    end
    if (stk_re) begin
      stack_rd_r <= stack_mem[stk_ra];
    end
  end

  // read returns the old mark while the walk clears it
  always_ff @(posedge clk) begin
    if (mk_re) begin
      mark_rd_r <= mark_mem[mk_ra];
    end
    if (mk_we) begin
      mark_mem[mk_wa] <= mk_wd;
    end
  end

  `FIDS_ASSERT(a_top_le_size, top_r <= size_r, "free count above active size")
  `FIDS_ASSERT(a_size_cap, size_r <= CW'(ID_CAPACITY) && high_r <= CW'(ID_CAPACITY), "size or highest mark above capacity")
  `FIDS_ASSERT(a_pop_nonempty, step_r != fids_pkg::S_POP || top_r != '0, "pop from empty stack")
  `FIDS_ASSERT_NEXT(a_emit_loads, step_r == fids_pkg::S_EMIT && !out_busy, out_valid_r && step_r == fids_pkg::S_FETCH, "result not loaded on emit")
  `FIDS_ASSERT_NEXT(a_walk_pending, step_r == fids_pkg::S_FRD, pv_r, "restore walk lost a pending entry")

endmodule

[verif/tb.sv]
// self-checking bench for free_id_stack_allocator: directed table, then random command traffic
// an in-bench predictor tracks the free-id stack, size and restore marks
// depends on rtl/core/fids_pkg.sv and rtl/core/free_id_stack_allocator.sv
module tb;

  localparam int CAPACITY      = 256;
  localparam int BASE_ID       = 1;
  localparam int START_SIZE    = 8;
  localparam int RANDOM_WORDS  = 1600;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 600;
  localparam int CYCLE_LIMIT   = 1500000;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  fids_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_stall;
  fids_pkg::out_item_t out_data;

  always #5 clk = ~clk;

  free_id_stack_allocator #(
    .ID_CAPACITY (CAPACITY),
    .FIRST_ID    (BASE_ID),
    .INITIAL_SIZE(START_SIZE)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  typedef struct {
    fids_pkg::in_item_t  word;
    bit                  typed;
    fids_pkg::out_item_t want;
  } stim_row_t;

  // predictor state
  logic [15:0] free_ids [CAPACITY];
  bit          id_marked [CAPACITY];
  int unsigned free_top;
  int unsigned live_size;
  int unsigned mark_span;

  stim_row_t           dir_rows[$];
  stim_row_t           offered_rows[$];
  fids_pkg::out_item_t pending_words[$];
  logic [15:0]         held_ids[$];

  int unsigned words_in, words_out, random_sent, err_cnt, cycle_cnt;
  int unsigned grant_cnt, exhaust_cnt, drop_cnt, rebuild_cnt, growth_cnt, hold_cnt;
  bit          calm;
  bit          hold_req;

  task automatic flag_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic load_descending(input int unsigned count, input int unsigned size);
    for (int unsigned i = 0; i < count && i < CAPACITY; i++)
      free_ids[i] = 16'(BASE_ID + size - 1 - i);
  endtask

  task automatic clear_marks();
    foreach (id_marked[i]) id_marked[i] = 1'b0;
    mark_span = 0;
  endtask

  task automatic allocator_reset();
    foreach (free_ids[i]) free_ids[i] = '0;
    live_size = (START_SIZE < CAPACITY) ? START_SIZE : CAPACITY;
    free_top  = live_size;
    load_descending(free_top, live_size);
    clear_marks();
  endtask

  task automatic predict_word(input fids_pkg::in_item_t w, output fids_pkg::out_item_t r);
    int unsigned prev_size, idx, need, req, cnt;
    r.granted_id = '0;
    r.status     = fids_pkg::ST_DONE;
    case (w.action)
      fids_pkg::ACT_GET: begin
        if (free_top == 0) begin
          if (live_size >= CAPACITY) begin
            r.status = fids_pkg::ST_EXHAUSTED;
          end else begin
            prev_size = live_size;
            live_size = (prev_size * 2 < CAPACITY) ? prev_size * 2 : CAPACITY;
            free_top  = live_size - prev_size;
            load_descending(free_top, live_size);
            growth_cnt++;
          end
        end
        if (r.status != fids_pkg::ST_EXHAUSTED && free_top > 0) begin
          free_top--;
          r.granted_id = free_ids[free_top];
          r.status     = fids_pkg::ST_GRANTED;
        end
      end
      fids_pkg::ACT_RELEASE: begin
        if (free_top >= live_size || free_top >= CAPACITY) begin
          r.status = fids_pkg::ST_FULL;
        end else begin
          free_ids[free_top] = w.id_value;
          free_top++;
        end
      end
      fids_pkg::ACT_BEGIN: clear_marks();
      fids_pkg::ACT_MARK: begin
        // ids below the range are ignored, ids above it only raise the span
        if (w.id_value >= BASE_ID) begin
          idx  = w.id_value - BASE_ID;
          need = (idx + 1 < CAPACITY) ? idx + 1 : CAPACITY;
          if (need > mark_span) mark_span = need;
          if (idx < CAPACITY) id_marked[idx] = 1'b1;
        end
      end
      fids_pkg::ACT_FINISH: begin
        req = live_size;
        if (mark_span > req) req = mark_span;
        if (req < START_SIZE) req = START_SIZE;
        if (req > CAPACITY) req = CAPACITY;
        if (req > live_size) live_size = req;
        cnt = 0;
        for (int unsigned k = req; k > 0; k--) begin
          if (!id_marked[k-1]) begin
            free_ids[cnt] = 16'(BASE_ID + k - 1);
            cnt++;
          end
        end
        free_top = cnt;
        clear_marks();
        rebuild_cnt++;
      end
      default: ;
    endcase
  endtask

  // accept side: predict at the input handshake, check at the output handshake
  always @(posedge clk) begin : watch
    fids_pkg::out_item_t model_out, want;
    stim_row_t row;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_word(in_data, model_out);
        row = offered_rows.pop_front();
        pending_words.push_back(row.typed ? row.want : model_out);
        if (model_out.status == fids_pkg::ST_GRANTED) begin
          grant_cnt++;
          if (model_out.granted_id >= BASE_ID && model_out.granted_id < BASE_ID + CAPACITY)
            held_ids.push_back(model_out.granted_id);
        end
        if (model_out.status == fids_pkg::ST_EXHAUSTED) exhaust_cnt++;
        if (model_out.status == fids_pkg::ST_FULL) drop_cnt++;
        words_in++;
      end
      if (out_valid && !out_stall) begin
        if (pending_words.size() == 0) begin
          flag_mismatch($sformatf("result word with nothing pending: id %0d status %0d",
                                  out_data.granted_id, out_data.status));
        end else begin
          want = pending_words.pop_front();
          if (out_data.granted_id !== want.granted_id)
            flag_mismatch($sformatf("word %0d granted_id got %0d want %0d",
                                    words_out, out_data.granted_id, want.granted_id));
          if (out_data.status !== want.status)
            flag_mismatch($sformatf("word %0d status got %0d want %0d",
                                    words_out, out_data.status, want.status));
        end
        words_out++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_cnt, pending_words.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic offer_word(input logic [2:0] act, input logic [15:0] id,
                            input bit typed, input fids_pkg::out_item_t want);
    stim_row_t   row;
    int          gap;
    int unsigned taken;
    row.word.action   = act;
    row.word.id_value = id;
    row.typed         = typed;
    row.want          = want;
    gap = calm ? 0 : $urandom_range(0, 3);
    offered_rows.push_back(row);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= row.word;
    taken = words_in;
    do @(negedge clk); while (words_in == taken);
    if (act <= fids_pkg::ACT_FINISH) random_sent++;
  endtask

  task automatic send(input logic [2:0] act, input logic [15:0] id);
    offer_word(act, id, 1'b0, '0);
  endtask

  task automatic add_row(input logic [2:0] act, input logic [15:0] id, input bit typed,
                         input logic [15:0] gid, input fids_pkg::status_t st);
    stim_row_t row;
    row.word.action    = act;
    row.word.id_value  = id;
    row.typed          = typed;
    row.want.granted_id = gid;
    row.want.status    = st;
    dir_rows.push_back(row);
  endtask

  initial begin : stimulus
    int          seg, n, pick, edge_sel, seg_cnt;
    logic [15:0] v;
    logic [15:0] kept[$];
    bit          first_seg;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    calm      = 1'b0;
    hold_req  = 1'b0;
    allocator_reset();

    // fresh stack pops 1..8
    add_row(fids_pkg::ACT_GET,     16'd0,    1, 16'd1,    fids_pkg::ST_GRANTED);
    add_row(fids_pkg::ACT_RELEASE, 16'd1,    1, 16'd0,    fids_pkg::ST_DONE);
    add_row(fids_pkg::ACT_RELEASE, 16'hFFFF, 1, 16'd0,    fids_pkg::ST_FULL);
    add_row(fids_pkg::ACT_GET,     16'hFFFF, 1, 16'd1,    fids_pkg::ST_GRANTED);
    // any value goes back on the stack as given
    add_row(fids_pkg::ACT_RELEASE, 16'hFFFF, 1, 16'd0,    fids_pkg::ST_DONE);
    add_row(fids_pkg::ACT_GET,     16'd0,    1, 16'hFFFF, fids_pkg::ST_GRANTED);
    add_row(3'd5,                  16'hAAAA, 1, 16'd0,    fids_pkg::ST_DONE);
    add_row(3'd6,                  16'h5555, 1, 16'd0,    fids_pkg::ST_DONE);
    add_row(3'd7,                  16'h0000, 1, 16'd0,    fids_pkg::ST_DONE);
    repeat (7) add_row(fids_pkg::ACT_GET, 16'h0000, 0, 16'd0, fids_pkg::ST_DONE);
    // empty stack: grows to 16
    add_row(fids_pkg::ACT_GET,     16'h0000, 0, 16'd0,    fids_pkg::ST_DONE);
    // mark above range with no begin; begin must wipe its span
    add_row(fids_pkg::ACT_MARK,    16'hFFFF, 1, 16'd0,    fids_pkg::ST_DONE);
    add_row(fids_pkg::ACT_BEGIN,   16'h0000, 1, 16'd0,    fids_pkg::ST_DONE);
    add_row(fids_pkg::ACT_MARK,    16'd0,    1, 16'd0,    fids_pkg::ST_DONE);
    add_row(fids_pkg::ACT_MARK,    16'd3,    1, 16'd0,    fids_pkg::ST_DONE);
    add_row(fids_pkg::ACT_MARK,    16'd12,   1, 16'd0,    fids_pkg::ST_DONE);
    add_row(fids_pkg::ACT_FINISH,  16'h0000, 1, 16'd0,    fids_pkg::ST_DONE);
    add_row(fids_pkg::ACT_GET,     16'h0000, 0, 16'd0,    fids_pkg::ST_DONE);
    add_row(fids_pkg::ACT_GET,     16'h0000, 0, 16'd0,    fids_pkg::ST_DONE);
    add_row(fids_pkg::ACT_RELEASE, 16'h0000, 0, 16'd0,    fids_pkg::ST_DONE);

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      offer_word(dir_rows[i].word.action, dir_rows[i].word.id_value,
                 dir_rows[i].typed, dir_rows[i].want);

    random_sent = 0;
    first_seg   = 1'b1;
    seg_cnt     = 0;
    while (random_sent < RANDOM_WORDS) begin
      calm = ($urandom_range(0, 4) == 0);
      // start with a drain so every growth step is walked before restores raise the size
      seg = first_seg ? 60 : $urandom_range(0, 99);
      first_seg = 1'b0;
      seg_cnt++;
      if (seg_cnt == 3 || seg_cnt == 25) hold_req = 1'b1;
      if (seg < 58) begin
        n = $urandom_range(15, 60);
        repeat (n) begin
          pick = $urandom_range(0, 99);
          if (pick < 55) begin
            send(fids_pkg::ACT_GET, 16'($urandom_range(0, 16'hFFFF)));
          end else if (pick < 95) begin
            if (held_ids.size() > 0 && $urandom_range(0, 3) != 0) begin
              n = $urandom_range(0, held_ids.size() - 1);
              v = held_ids[n];
              held_ids.delete(n);
            end else begin
              v = 16'($urandom_range(0, 16'hFFFF));
            end
            send(fids_pkg::ACT_RELEASE, v);
          end else if (pick < 98) begin
            send(3'($urandom_range(5, 7)), 16'($urandom_range(0, 16'hFFFF)));
          end else begin
            send(fids_pkg::ACT_MARK, 16'($urandom_range(0, 16'hFFFF)));
          end
        end
      end else if (seg < 62) begin
        // enough gets to empty every size step and run into exhaustion
        n = free_top + (CAPACITY - live_size) + $urandom_range(1, 6);
        repeat (n) send(fids_pkg::ACT_GET, 16'($urandom_range(0, 16'hFFFF)));
      end else if (seg < 90) begin
        send(fids_pkg::ACT_BEGIN, 16'($urandom_range(0, 16'hFFFF)));
        kept.delete();
        n = $urandom_range(0, 12);
        repeat (n) begin
          pick = $urandom_range(0, 9);
          if (pick < 7 && held_ids.size() > 0) begin
            v = held_ids[$urandom_range(0, held_ids.size() - 1)];
          end else if (pick < 8) begin
            v = 16'($urandom_range(0, 16'hFFFF));
          end else begin
            edge_sel = $urandom_range(0, 3);
            v = (edge_sel < 2) ? 16'(BASE_ID - 1 + edge_sel)
                               : 16'(BASE_ID + CAPACITY - 3 + edge_sel);
          end
          send(fids_pkg::ACT_MARK, v);
          if (v >= BASE_ID && v < BASE_ID + CAPACITY) kept.push_back(v);
        end
        send(fids_pkg::ACT_FINISH, 16'($urandom_range(0, 16'hFFFF)));
        held_ids = kept;
      end else begin
        // broken restore sequences
        case ($urandom_range(0, 3))
          0: repeat ($urandom_range(1, 4))
               send(fids_pkg::ACT_MARK, 16'($urandom_range(0, 300)));
          1: begin
            send(fids_pkg::ACT_FINISH, 16'($urandom_range(0, 16'hFFFF)));
            held_ids.delete();
          end
          2: begin
            send(fids_pkg::ACT_BEGIN, 16'($urandom_range(0, 16'hFFFF)));
            send(fids_pkg::ACT_BEGIN, 16'($urandom_range(0, 16'hFFFF)));
          end
          default: begin
            send(fids_pkg::ACT_BEGIN, 16'($urandom_range(0, 16'hFFFF)));
            send(fids_pkg::ACT_MARK, 16'($urandom_range(0, 300)));
          end
        endcase
      end
    end

    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("ran %0d command words (%0d from the table), checked %0d results, %0d errors",
             words_in, dir_rows.size(), words_out, err_cnt);
    $display("grants %0d, exhausted %0d, full drops %0d, rebuilds %0d, growths %0d, holds %0d",
             grant_cnt, exhaust_cnt, drop_cnt, rebuild_cnt, growth_cnt, hold_cnt);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // result side back-pressure, with a couple of long holds to fill the block
  initial begin : receiver
    int          n;
    int          calm_left;
    int unsigned seen;
    calm_left = 0;
    wait (rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_cnt++;
      end else begin
        if (calm_left > 0) begin
          n = 0;
          calm_left--;
        end else begin
          n = $urandom_range(0, 3);
          if ($urandom_range(0, 19) == 0) calm_left = 25;
        end
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(negedge clk);
        end
      end
      out_stall <= 1'b0;
      seen = words_out;
      do @(negedge clk); while (words_out == seen);
    end
  end

endmodule
